// File: rtl/ivot_pkg.sv
// shared types and codes for the interrupt vector owner table
`timescale 1ns / 1ps

package ivot_pkg;

   localparam logic [2:0] OP_ACQUIRE   = 3'd0;
   localparam logic [2:0] OP_LOCK      = 3'd1;
   localparam logic [2:0] OP_RELEASE   = 3'd2;
   localparam logic [2:0] OP_UPDATE    = 3'd3;
   localparam logic [2:0] OP_REL_OWNER = 3'd4;
   localparam logic [2:0] OP_QUERY     = 3'd5;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_BAD_ARG   = 3'd1;
   localparam logic [2:0] STATUS_OWNED     = 3'd2;
   localparam logic [2:0] STATUS_NOT_OWNED = 3'd3;
   localparam logic [2:0] STATUS_FULL      = 3'd4;

   typedef enum logic [2:0] {
      FIN_NONE,
      FIN_BAD,
      FIN_SINGLE,
      FIN_QUERY,
      FIN_GRANT,
      FIN_FULL,
      FIN_OWN
   } fin_type;

   typedef struct packed {
      logic    load;
      logic    idx_inc;
      logic    own_issue;
      logic    own_cmp;
      fin_type fin;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       arg_bad;
      logic       idx_last;
      logic       free_hit;
   } dp_status_type;

endpackage

// File: rtl/ivot_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module ivot_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/ivot_datapath.sv
// request registers, valid bits, table memories and result registers
`timescale 1ns / 1ps

module ivot_datapath #(
   parameter int NUM_VECTORS = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ivot_pkg::ctrl_cmd_type cmd,
   output ivot_pkg::dp_status_type st,
   input  logic [2:0]             req_op,
   input  logic [7:0]             req_vector,
   input  logic [31:0]            req_owner,
   input  logic [31:0]            req_handler,
   output logic                   rsp_ok,
   output logic [2:0]             rsp_status,
   output logic [7:0]             rsp_vector_out,
   output logic [31:0]            rsp_owner_out,
   output logic [31:0]            rsp_handler_out,
   output logic [8:0]             rsp_freed_count
);

   localparam int IDX_W = $clog2(NUM_VECTORS);

   logic [2:0]       op_ff, op_in;
   logic [7:0]       vec_ff, vec_in;
   logic [31:0]      own_ff, own_in;
   logic [31:0]      hnd_ff, hnd_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             pend_ff, pend_in;
   logic [8:0]       count_ff, count_in;
   logic             valid_ff [NUM_VECTORS];
   logic             valid_in [NUM_VECTORS];

   logic [2:0]       status_ff, status_in;
   logic [7:0]       vout_ff, vout_in;
   logic [31:0]      oout_ff, oout_in;
   logic [31:0]      hout_ff, hout_in;
   logic [8:0]       cnt_ff, cnt_in;

   logic [IDX_W-1:0] vec_idx;
   logic             in_range;
   logic             own_zero;
   logic             arg_bad;
   logic             match;
   logic             owner_we;
   logic             handler_we;
   logic [IDX_W-1:0] waddr;
   logic [IDX_W-1:0] raddr;
   logic [31:0]      owner_rd;
   logic [31:0]      handler_rd;

   assign vec_idx  = vec_ff[IDX_W-1:0];
   assign in_range = {1'b0, vec_ff} < 9'(NUM_VECTORS);
   assign own_zero = own_ff == 32'd0;
   assign match    = pend_ff && valid_ff[cmp_idx_ff] && (owner_rd == own_ff);
   assign raddr    = cmd.own_issue ? idx_ff : vec_idx;

   always_comb begin
      case (op_ff)
         ivot_pkg::OP_ACQUIRE, ivot_pkg::OP_REL_OWNER: arg_bad = own_zero;
         ivot_pkg::OP_LOCK:                            arg_bad = own_zero || !in_range;
         ivot_pkg::OP_RELEASE, ivot_pkg::OP_UPDATE,
         ivot_pkg::OP_QUERY:                           arg_bad = !in_range;
         default:                                      arg_bad = 1'b1;
      endcase
   end

   assign st.arg_bad  = arg_bad;
   assign st.op       = op_ff;
   assign st.idx_last = idx_ff == IDX_W'(NUM_VECTORS - 1);
   assign st.free_hit = !valid_ff[idx_ff];

   always_comb begin
      op_in      = op_ff;
      vec_in     = vec_ff;
      own_in     = own_ff;
      hnd_in     = hnd_ff;
      idx_in     = idx_ff;
      cmp_idx_in = cmp_idx_ff;
      pend_in    = pend_ff;
      count_in   = count_ff;
      valid_in   = valid_ff;
      status_in  = status_ff;
      vout_in    = vout_ff;
      oout_in    = oout_ff;
      hout_in    = hout_ff;
      cnt_in     = cnt_ff;
      owner_we   = 1'b0;
      handler_we = 1'b0;
      waddr      = vec_idx;

      if (cmd.load) begin
         op_in    = req_op;
         vec_in   = req_vector;
         own_in   = req_owner;
         hnd_in   = req_handler;
         idx_in   = '0;
         count_in = '0;
         pend_in  = 1'b0;
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end
      if (cmd.own_issue) begin
         pend_in    = 1'b1;
         cmp_idx_in = idx_ff;
      end
      if (cmd.own_cmp && match) begin
         valid_in[cmp_idx_ff] = 1'b0;
         count_in             = count_ff + 9'd1;
      end

      if (cmd.fin != ivot_pkg::FIN_NONE) begin
         status_in = ivot_pkg::STATUS_OK;
         vout_in   = '0;
         oout_in   = '0;
         hout_in   = '0;
         cnt_in    = '0;
      end
      case (cmd.fin)
         ivot_pkg::FIN_NONE: begin
         end
         ivot_pkg::FIN_BAD: begin
            status_in = ivot_pkg::STATUS_BAD_ARG;
         end
         ivot_pkg::FIN_SINGLE: begin
            case (op_ff)
               ivot_pkg::OP_LOCK: begin
                  if (valid_ff[vec_idx]) begin
                     status_in = ivot_pkg::STATUS_OWNED;
                  end else begin
                     owner_we          = 1'b1;
                     handler_we        = 1'b1;
                     valid_in[vec_idx] = 1'b1;
                  end
               end
               ivot_pkg::OP_RELEASE: begin
                  valid_in[vec_idx] = 1'b0;
               end
               ivot_pkg::OP_UPDATE: begin
                  if (valid_ff[vec_idx]) begin
                     handler_we = 1'b1;
                  end else begin
                     status_in = ivot_pkg::STATUS_NOT_OWNED;
                  end
               end
               default: begin
                  status_in = ivot_pkg::STATUS_BAD_ARG;
               end
            endcase
         end
         ivot_pkg::FIN_QUERY: begin
            if (valid_ff[vec_idx]) begin
               oout_in = owner_rd;
               hout_in = handler_rd;
            end else begin
               status_in = ivot_pkg::STATUS_NOT_OWNED;
            end
         end
         ivot_pkg::FIN_GRANT: begin
            owner_we         = 1'b1;
            handler_we       = 1'b1;
            waddr            = idx_ff;
            valid_in[idx_ff] = 1'b1;
            vout_in          = 8'(idx_ff);
         end
         ivot_pkg::FIN_FULL: begin
            status_in = ivot_pkg::STATUS_FULL;
         end
         ivot_pkg::FIN_OWN: begin
            cnt_in = count_in;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         count_ff <= '0;
         for (int i = 0; i < NUM_VECTORS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         pend_ff  <= pend_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      op_ff      <= op_in;
      vec_ff     <= vec_in;
      own_ff     <= own_in;
      hnd_ff     <= hnd_in;
      idx_ff     <= idx_in;
      cmp_idx_ff <= cmp_idx_in;
      status_ff  <= status_in;
      vout_ff    <= vout_in;
      oout_ff    <= oout_in;
      hout_ff    <= hout_in;
      cnt_ff     <= cnt_in;
   end

   ivot_ram #(
      .WIDTH (32),
      .DEPTH (NUM_VECTORS)
   ) u_owner_ram (
      .clock (clock),
      .we    (owner_we),
      .waddr (waddr),
      .wdata (own_ff),
      .raddr (raddr),
      .rdata (owner_rd)
   );

   ivot_ram #(
      .WIDTH (32),
      .DEPTH (NUM_VECTORS)
   ) u_handler_ram (
      .clock (clock),
      .we    (handler_we),
      .waddr (waddr),
      .wdata (hnd_ff),
      .raddr (raddr),
      .rdata (handler_rd)
   );

   assign rsp_ok          = status_ff == ivot_pkg::STATUS_OK;
   assign rsp_status      = status_ff;
   assign rsp_vector_out  = vout_ff;
   assign rsp_owner_out   = oout_ff;
   assign rsp_handler_out = hout_ff;
   assign rsp_freed_count = cnt_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 9'(NUM_VECTORS))
      else $error("freed count exceeds table size");

endmodule

// File: rtl/ivot_ctrl.sv
// request sequencer for the vector owner table
`timescale 1ns / 1ps

module ivot_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output logic                    rsp_strobe,
   output ivot_pkg::ctrl_cmd_type  cmd,
   input  ivot_pkg::dp_status_type st
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_QUERY,
      S_FREE,
      S_OWN,
      S_OWN_END
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_strobe_ff;

   always_comb begin
      state_in      = state_ff;
      cmd.load      = 1'b0;
      cmd.idx_inc   = 1'b0;
      cmd.own_issue = 1'b0;
      cmd.own_cmp   = 1'b0;
      cmd.fin       = ivot_pkg::FIN_NONE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (st.arg_bad) begin
               cmd.fin  = ivot_pkg::FIN_BAD;
               state_in = S_IDLE;
            end else begin
               case (st.op)
                  ivot_pkg::OP_ACQUIRE:   state_in = S_FREE;
                  ivot_pkg::OP_REL_OWNER: state_in = S_OWN;
                  ivot_pkg::OP_QUERY:     state_in = S_QUERY;
                  default: begin
                     cmd.fin  = ivot_pkg::FIN_SINGLE;
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_QUERY: begin
            cmd.fin  = ivot_pkg::FIN_QUERY;
            state_in = S_IDLE;
         end
         S_FREE: begin
            if (st.free_hit) begin
               cmd.fin  = ivot_pkg::FIN_GRANT;
               state_in = S_IDLE;
            end else if (st.idx_last) begin
               cmd.fin  = ivot_pkg::FIN_FULL;
               state_in = S_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_OWN: begin
            cmd.own_issue = 1'b1;
            cmd.own_cmp   = 1'b1;
            cmd.idx_inc   = 1'b1;
            if (st.idx_last) begin
               state_in = S_OWN_END;
            end
         end
         S_OWN_END: begin
            cmd.own_cmp = 1'b1;
            cmd.fin     = ivot_pkg::FIN_OWN;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= cmd.fin != ivot_pkg::FIN_NONE;
      end
   end

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = rsp_strobe_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   a_strobe_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff != S_IDLE))
      else $error("result strobe without a request in progress");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two result strobes in a row");

endmodule

// File: rtl/interrupt_vector_owner_table.sv
// top level of the interrupt vector owner table
// one request at a time: the next word is taken at the edge that ends the result strobe
// lock, release, update, bad argument: result set in the check state; query: in the query state after it
// acquire: one vector checked per cycle for first free
// release owner: one owner memory read per vector
// reset clears the owned bits at once, so the table is empty with no clearing pass
`timescale 1ns / 1ps

module interrupt_vector_owner_table #(
   parameter int NUM_VECTORS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_op,
   input  logic [7:0]  req_vector,
   input  logic [31:0] req_owner,
   input  logic [31:0] req_handler,
   output logic        rsp_strobe,
   output logic        rsp_ok,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_vector_out,
   output logic [31:0] rsp_owner_out,
   output logic [31:0] rsp_handler_out,
   output logic [8:0]  rsp_freed_count
);

   ivot_pkg::ctrl_cmd_type  cmd;
   ivot_pkg::dp_status_type st;

   ivot_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .st         (st)
   );

   ivot_datapath #(
      .NUM_VECTORS (NUM_VECTORS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .req_op          (req_op),
      .req_vector      (req_vector),
      .req_owner       (req_owner),
      .req_handler     (req_handler),
      .rsp_ok          (rsp_ok),
      .rsp_status      (rsp_status),
      .rsp_vector_out  (rsp_vector_out),
      .rsp_owner_out   (rsp_owner_out),
      .rsp_handler_out (rsp_handler_out),
      .rsp_freed_count (rsp_freed_count)
   );

endmodule

// File: verif/tb_interrupt_vector_owner_table.sv
// testbench for the interrupt vector owner table: directed and random requests, scoreboard check
`timescale 1ns / 1ps

module tb_interrupt_vector_owner_table;
   import ivot_pkg::*;

   localparam int NUM_VEC = 256;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int OWNER_POOL_SIZE = 6;
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   typedef struct packed {
      logic        ok;
      logic [2:0]  status;
      logic [7:0]  vector_out;
      logic [31:0] owner_out;
      logic [31:0] handler_out;
      logic [8:0]  freed_count;
   } rsp_word_type;

   class vector_table_scoreboard;
      logic [31:0]  owner_tbl [NUM_VEC];
      logic [31:0]  handler_tbl [NUM_VEC];
      rsp_word_type expected_q [$];
      int           errors;

      function new();
         for (int i = 0; i < NUM_VEC; i++) begin
            owner_tbl[i] = '0;
            handler_tbl[i] = '0;
         end
         errors = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // predict the response of one accepted word and update the table copy
      function void note_request(logic [2:0] op, logic [7:0] vec, logic [31:0] own,
                                 logic [31:0] hnd);
         rsp_word_type e;
         bit           in_range;
         bit           found;
         int           cnt;
         e = '0;
         in_range = int'(vec) < NUM_VEC;
         found = 1'b0;
         cnt = 0;
         case (op)
            OP_ACQUIRE: begin
               if (own == '0) begin
                  e.status = STATUS_BAD_ARG;
               end else begin
                  e.status = STATUS_FULL;
                  for (int i = 0; i < NUM_VEC; i++) begin
                     if (!found && owner_tbl[i] == '0) begin
                        found = 1'b1;
                        owner_tbl[i] = own;
                        handler_tbl[i] = hnd;
                        e.status = STATUS_OK;
                        e.vector_out = 8'(i);
                     end
                  end
               end
            end
            OP_LOCK: begin
               if (own == '0 || !in_range) begin
                  e.status = STATUS_BAD_ARG;
               end else if (owner_tbl[vec] != '0) begin
                  e.status = STATUS_OWNED;
               end else begin
                  owner_tbl[vec] = own;
                  handler_tbl[vec] = hnd;
                  e.status = STATUS_OK;
               end
            end
            OP_RELEASE: begin
               if (!in_range) begin
                  e.status = STATUS_BAD_ARG;
               end else begin
                  owner_tbl[vec] = '0;
                  handler_tbl[vec] = '0;
                  e.status = STATUS_OK;
               end
            end
            OP_UPDATE: begin
               if (!in_range) begin
                  e.status = STATUS_BAD_ARG;
               end else if (owner_tbl[vec] == '0) begin
                  e.status = STATUS_NOT_OWNED;
               end else begin
                  handler_tbl[vec] = hnd;
                  e.status = STATUS_OK;
               end
            end
            OP_REL_OWNER: begin
               if (own == '0) begin
                  e.status = STATUS_BAD_ARG;
               end else begin
                  for (int i = 0; i < NUM_VEC; i++) begin
                     if (owner_tbl[i] == own) begin
                        owner_tbl[i] = '0;
                        handler_tbl[i] = '0;
                        cnt++;
                     end
                  end
                  e.status = STATUS_OK;
                  e.freed_count = 9'(cnt);
               end
            end
            OP_QUERY: begin
               if (!in_range) begin
                  e.status = STATUS_BAD_ARG;
               end else if (owner_tbl[vec] == '0) begin
                  e.status = STATUS_NOT_OWNED;
               end else begin
                  e.status = STATUS_OK;
                  e.owner_out = owner_tbl[vec];
                  e.handler_out = handler_tbl[vec];
               end
            end
            default: begin
               e.status = STATUS_BAD_ARG;
            end
         endcase
         e.ok = (e.status == STATUS_OK);
         expected_q.push_back(e);
      endfunction

      function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (act_v !== exp_v) begin
            $display("%0t ERROR %s expected %0h actual %0h", $time, name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_response(rsp_word_type got);
         rsp_word_type e;
         if (expected_q.size() == 0) begin
            $display("%0t ERROR response with none expected, actual %0h", $time, got);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         compare_field("ok", 32'(e.ok), 32'(got.ok));
         compare_field("status", 32'(e.status), 32'(got.status));
         compare_field("vector_out", 32'(e.vector_out), 32'(got.vector_out));
         compare_field("owner_out", e.owner_out, got.owner_out);
         compare_field("handler_out", e.handler_out, got.handler_out);
         compare_field("freed_count", 32'(e.freed_count), 32'(got.freed_count));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_op;
   logic [7:0]  req_vector;
   logic [31:0] req_owner;
   logic [31:0] req_handler;
   logic        rsp_strobe;
   logic        rsp_ok;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_vector_out;
   logic [31:0] rsp_owner_out;
   logic [31:0] rsp_handler_out;
   logic [8:0]  rsp_freed_count;

   vector_table_scoreboard sb;
   logic [31:0] owner_pool [OWNER_POOL_SIZE];
   int          burst_left;
   bit          hold_next;
   int          idle_cycles;

   interrupt_vector_owner_table #(.NUM_VECTORS(NUM_VEC)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_vector(req_vector),
      .req_owner(req_owner),
      .req_handler(req_handler),
      .rsp_strobe(rsp_strobe),
      .rsp_ok(rsp_ok),
      .rsp_status(rsp_status),
      .rsp_vector_out(rsp_vector_out),
      .rsp_owner_out(rsp_owner_out),
      .rsp_handler_out(rsp_handler_out),
      .rsp_freed_count(rsp_freed_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_word_type got;
      if (!reset) begin
         if (start && !busy) begin
            sb.note_request(req_op, req_vector, req_owner, req_handler);
         end
         if (rsp_strobe) begin
            got.ok = rsp_ok;
            got.status = rsp_status;
            got.vector_out = rsp_vector_out;
            got.owner_out = rsp_owner_out;
            got.handler_out = rsp_handler_out;
            got.freed_count = rsp_freed_count;
            sb.check_response(got);
         end
         if ((start && !busy) || rsp_strobe) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog expired, %0d responses outstanding", $time, sb.pending());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   function int next_gap();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(13, 300);
      end
      return $urandom_range(1, 12);
   endfunction

   // present one word, wait for it to be taken, then idle as the burst pattern says, or until no response is pending
   task send_word(input logic [2:0] op, input logic [7:0] vec, input logic [31:0] own,
                  input logic [31:0] hnd);
      req_op <= op;
      req_vector <= vec;
      req_owner <= own;
      req_handler <= hnd;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      if (hold_next) begin
         hold_next = 1'b0;
         start <= 1'b0;
         do @(posedge clock); while (sb.pending() != 0);
      end else begin
         if (burst_left > 0) begin
            burst_left--;
         end
         if (burst_left == 0) begin
            start <= 1'b0;
            repeat (next_gap()) @(posedge clock);
            burst_left = $urandom_range(1, 40);
         end
      end
   endtask

   function logic [31:0] pick_owner();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         return '0;
      end else if (roll < 15) begin
         return $urandom;
      end
      return owner_pool[$urandom_range(0, OWNER_POOL_SIZE - 1)];
   endfunction

   function logic [7:0] pick_vector();
      if ($urandom_range(0, 1) == 0) begin
         return 8'($urandom_range(0, 31));
      end
      return 8'($urandom_range(0, 255));
   endfunction

   function logic [31:0] pick_handler();
      if ($urandom_range(0, 9) == 0) begin
         return '0;
      end
      return $urandom;
   endfunction

   task rand_word(input int acq_pct, input int relown_pct);
      int         roll;
      logic [2:0] op;
      roll = $urandom_range(0, 99);
      if (roll < acq_pct) begin
         op = OP_ACQUIRE;
      end else if (roll < acq_pct + relown_pct) begin
         op = OP_REL_OWNER;
      end else if (roll < acq_pct + relown_pct + 2) begin
         op = ($urandom_range(0, 1) == 0) ? OP_SPARE_A : OP_SPARE_B;
      end else begin
         case ($urandom_range(0, 3))
            0: op = OP_LOCK;
            1: op = OP_RELEASE;
            2: op = OP_UPDATE;
            default: op = OP_QUERY;
         endcase
      end
      send_word(op, pick_vector(), pick_owner(), pick_handler());
   endtask

   // fill toward a full table, churn, then free every pooled owner
   task run_round();
      repeat (329) rand_word(80, 0);
      hold_next = 1'b1;
      rand_word(80, 0);
      repeat (110) rand_word(20, 3);
      for (int k = 0; k < OWNER_POOL_SIZE; k++) begin
         send_word(OP_REL_OWNER, pick_vector(), owner_pool[k], $urandom);
      end
      hold_next = 1'b1;
      send_word(OP_REL_OWNER, pick_vector(), $urandom | 32'h1, $urandom);
   endtask

   initial begin
      sb = new();
      start = 1'b0;
      req_op = OP_ACQUIRE;
      req_vector = '0;
      req_owner = '0;
      req_handler = '0;
      reset = 1'b1;
      idle_cycles = 0;
      hold_next = 1'b0;
      burst_left = $urandom_range(1, 40);
      owner_pool[0] = 32'h1;
      owner_pool[1] = 32'hFFFF_FFFF;
      for (int k = 2; k < OWNER_POOL_SIZE; k++) begin
         owner_pool[k] = $urandom | 32'h2;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // free table, zero owners
      send_word(OP_QUERY, 8'd0, 32'h1, 32'h0);
      send_word(OP_UPDATE, 8'd255, 32'h1, 32'h1234_5678);
      send_word(OP_RELEASE, 8'd7, 32'h0, 32'h0);
      send_word(OP_ACQUIRE, 8'd0, 32'h0, 32'hFFFF_FFFF);
      send_word(OP_LOCK, 8'd3, 32'h0, 32'h1);
      send_word(OP_REL_OWNER, 8'd0, 32'h0, 32'h0);
      // grants, lock of an owned vector, handler clear
      send_word(OP_ACQUIRE, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(OP_ACQUIRE, 8'd0, 32'h1, 32'h0);
      send_word(OP_LOCK, 8'd255, 32'h1, 32'hA5A5_A5A5);
      send_word(OP_LOCK, 8'd255, 32'h2, 32'h5A5A_5A5A);
      send_word(OP_QUERY, 8'd255, 32'h0, 32'h0);
      send_word(OP_UPDATE, 8'd255, 32'h0, 32'h0);
      send_word(OP_QUERY, 8'd255, 32'h0, 32'h0);
      send_word(OP_UPDATE, 8'd0, 32'h0, 32'h5A5A_5A5A);
      send_word(OP_QUERY, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // unused op codes
      send_word(OP_SPARE_A, 8'd0, 32'h1, 32'h1);
      send_word(OP_SPARE_B, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // lowest free vector is reused, release by owner counts
      send_word(OP_RELEASE, 8'd1, 32'h0, 32'h0);
      send_word(OP_ACQUIRE, 8'd0, 32'h1, 32'h0000_0001);
      send_word(OP_REL_OWNER, 8'd0, 32'h1, 32'h0);
      send_word(OP_REL_OWNER, 8'd0, 32'hFFFF_FFFF, 32'h0);
      send_word(OP_REL_OWNER, 8'd0, 32'h1, 32'h0);
      hold_next = 1'b1;
      send_word(OP_QUERY, 8'd255, 32'h0, 32'h0);

      repeat (3) run_round();

      repeat (NUM_VEC + 8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
